// ===== rtl/sls_pkg.sv =====
package sls_pkg;

    // operation codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LVL,
        ST_RDPTR,
        ST_RDKEY,
        ST_CMP,
        ST_DECIDE,
        ST_INS,
        ST_DEL,
        ST_TOPDN,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic lvl_init;
        logic rd_ptr;
        logic rd_key;
        logic advance;
        logic lvl_down;
        logic decide;
        logic ins_step;
        logic del_step;
        logic top_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic more;
        logic lvl_zero;
        logic do_ins;
        logic do_del;
        logic step_last;
        logic top_done;
    } stat_t;

endpackage

// ===== rtl/sls_ctrl.sv =====
module sls_ctrl
    import sls_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_LVL;
            ST_LVL:    state_next = ST_RDPTR;
            ST_RDPTR:  state_next = ST_RDKEY;
            ST_RDKEY:  state_next = ST_CMP;
            ST_CMP:
            begin
                if (stat.more)          state_next = ST_RDPTR;
                else if (stat.lvl_zero) state_next = ST_DECIDE;
                else                    state_next = ST_RDPTR;
            end
            ST_DECIDE:
            begin
                if (stat.do_ins)      state_next = ST_INS;
                else if (stat.do_del) state_next = ST_DEL;
                else                  state_next = ST_OUT;
            end
            ST_INS:    if (stat.step_last) state_next = ST_OUT;
            ST_DEL:    if (stat.step_last) state_next = ST_TOPDN;
            ST_TOPDN:  if (stat.top_done)  state_next = ST_OUT;
            ST_OUT:    if (out_ready)      state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_LVL:    cmd.lvl_init = 1'b1;
            ST_RDPTR:  cmd.rd_ptr = 1'b1;
            ST_RDKEY:  cmd.rd_key = 1'b1;
            ST_CMP:
            begin
                cmd.advance  = stat.more;
                cmd.lvl_down = !stat.more && !stat.lvl_zero;
            end
            ST_DECIDE: cmd.decide = 1'b1;
            ST_INS:    cmd.ins_step = 1'b1;
            ST_DEL:    cmd.del_step = 1'b1;
            ST_TOPDN:  cmd.top_step = 1'b1;
            ST_OUT:    out_valid = 1'b1;
            default:   cmd = '0;
        endcase
    end

endmodule

// ===== rtl/sls_dp.sv =====
module sls_dp
    import sls_pkg::*;
#(
    parameter int MAX_LEVELS = 5,
    parameter int POOL_NODES = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         func,
    input  logic signed [31:0] key,
    input  cmd_t               cmd,
    output stat_t              stat,
    output logic               found,
    output logic               full_res
);

    localparam int NW = $clog2(POOL_NODES);
    localparam int PW = NW + 1;          // node pointer, POOL_NODES is null
    localparam int LW = $clog2(MAX_LEVELS + 1);
    localparam int IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int AW = $clog2(POOL_NODES * MAX_LEVELS);
    localparam int CW = $clog2(POOL_NODES + 1);
    localparam logic [PW-1:0] NIL = PW'(POOL_NODES);
    // reciprocal of MAX_LEVELS, exact for every 16-bit lfsr value
    localparam int MS = 16 + $clog2(MAX_LEVELS);
    localparam int MW = MS + 1;
    localparam logic [MS:0] MR =
        MW'(((64'd1 << MS) + 64'(MAX_LEVELS - 1)) / 64'(MAX_LEVELS));

    // memories
    logic [31:0]   key_mem  [POOL_NODES];
    logic [PW-1:0] link_mem [POOL_NODES * MAX_LEVELS];
    logic [NW-1:0] free_mem [POOL_NODES];

    // per-level state held in flops
    logic [PW-1:0] head_reg [MAX_LEVELS];
    logic [PW-1:0] pred_reg [MAX_LEVELS];    // NIL marks the head
    logic [PW-1:0] succ_reg [MAX_LEVELS];    // pred's next on each level

    logic [LW-1:0] top_reg;
    logic [CW-1:0] free_cnt_reg;
    logic [CW-1:0] fill_reg;                 // lowest free stack entry written
    logic [15:0]   lfsr_reg;
    logic [1:0]    func_reg;
    logic [31:0]   k_reg;
    logic [PW-1:0] cur_reg;
    logic [PW-1:0] nx_reg;
    logic [31:0]   nkey_reg;
    logic [IW-1:0] lvl_reg;
    logic [LW-1:0] step_reg;
    logic [LW-1:0] nlv_reg;
    logic [NW-1:0] nn_reg;
    logic [PW-1:0] cand_reg;
    logic          del_brk_reg;
    logic          found_reg, full_reg;
    logic [PW-1:0] lrd_reg;
    logic [NW-1:0] free_mem_q;

    // combinational helpers
    logic [15:0]   lfsr_step;
    logic [MS+16:0] lv_prod;
    logic [15:0]   lv_quo;
    logic [15:0]   lv_rem;
    logic [LW-1:0] lv_draw;
    logic [NW-1:0] free_top;
    logic [IW-1:0] sidx;
    logic [PW-1:0] link_addr_node;
    logic [AW-1:0] rd_addr;
    logic [PW-1:0] nx_sel;
    logic          is_found;

    // next lfsr value and the level it draws, mod by reciprocal multiply
    always_comb
    begin
        lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
        if (lfsr_step == 16'd0)
            lfsr_step = LFSR_SEED;
        lv_prod = {{(MS+1){1'b0}}, lfsr_step} * {16'd0, MR};
        lv_quo  = lv_prod[MS+15:MS];
        lv_rem  = lfsr_step - lv_quo * 16'(MAX_LEVELS);
        lv_draw = LW'(lv_rem) + LW'(1);
    end

    assign sidx     = step_reg[IW-1:0];
    assign is_found = (succ_reg[0] != NIL) && (nkey_reg == k_reg) && cand_reg == succ_reg[0];
    assign free_top = (free_cnt_reg - CW'(1) >= fill_reg) ?
                      free_mem_q : NW'(free_cnt_reg - CW'(1));

    always_ff @(posedge clk)
    begin
        free_mem_q <= free_mem[NW'(free_cnt_reg - CW'(1))];
    end

    // link read address: walk node, or the found node from decide on
    assign link_addr_node = cmd.decide ? cand_reg : cur_reg;
    assign rd_addr = AW'(link_addr_node[NW-1:0] * MAX_LEVELS + lvl_reg);

    // next node on the current level
    assign nx_sel = (cur_reg == NIL) ? head_reg[lvl_reg] : lrd_reg;

    // status
    assign stat.more      = (nx_reg != NIL) && (nkey_reg < k_reg);
    assign stat.lvl_zero  = (lvl_reg == '0);
    assign stat.do_ins    = (func_reg == FUNC_INSERT) && !is_found && (free_cnt_reg != '0);
    assign stat.do_del    = (func_reg == FUNC_DELETE) && is_found;
    assign stat.step_last = cmd.ins_step ? (step_reg == nlv_reg - LW'(1))
                                         : (step_reg == top_reg - LW'(1));
    assign stat.top_done  = (top_reg <= LW'(1)) || (head_reg[top_reg - LW'(1)] != NIL);

    assign found    = found_reg;
    assign full_res = full_reg;

    // link memory read port
    always_ff @(posedge clk)
    begin
        lrd_reg <= link_mem[rd_addr];
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.ins_step)
        begin
            link_mem[AW'(nn_reg * MAX_LEVELS + sidx)] <=
                (step_reg < nlv_reg) ? ((pred_reg[sidx] == NIL) ? head_reg[sidx] :
                succ_reg[sidx]) : NIL;
            if (step_reg == '0)
                key_mem[nn_reg] <= k_reg;
        end
        if (cmd.ins_step && step_reg < nlv_reg && pred_reg[sidx] != NIL)
            link_mem[AW'(pred_reg[sidx][NW-1:0] * MAX_LEVELS + sidx)] <= PW'(nn_reg);
        if (cmd.del_step && !del_brk_reg && succ_reg[sidx] == cand_reg
            && pred_reg[sidx] != NIL)
            link_mem[AW'(pred_reg[sidx][NW-1:0] * MAX_LEVELS + sidx)] <= lrd_reg;
        if (cmd.decide && stat.do_del)
            free_mem[free_cnt_reg[NW-1:0]] <= cand_reg[NW-1:0];
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg      <= LW'(1);
            free_cnt_reg <= CW'(POOL_NODES);
            fill_reg     <= CW'(POOL_NODES);
            lfsr_reg     <= LFSR_SEED;
            for (int i = 0; i < MAX_LEVELS; i++)
                head_reg[i] <= NIL;
            found_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.decide)
            begin
                found_reg <= is_found;
                full_reg  <= (func_reg == FUNC_INSERT) && !is_found && (free_cnt_reg == '0);
                if (stat.do_ins)
                begin
                    lfsr_reg     <= lfsr_step;
                    free_cnt_reg <= free_cnt_reg - CW'(1);
                    if (lv_draw > top_reg)
                        top_reg <= lv_draw;
                end
                if (stat.do_del)
                begin
                    free_cnt_reg <= free_cnt_reg + CW'(1);
                    if (free_cnt_reg < fill_reg)
                        fill_reg <= free_cnt_reg;
                end
            end
            if (cmd.ins_step && step_reg < nlv_reg && pred_reg[sidx] == NIL)
                head_reg[sidx] <= PW'(nn_reg);
            if (cmd.del_step && !del_brk_reg && succ_reg[sidx] == cand_reg
                && pred_reg[sidx] == NIL)
                head_reg[sidx] <= lrd_reg;
            if (cmd.top_step && !stat.top_done)
                top_reg <= top_reg - LW'(1);
        end
    end

    // walk and step registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            k_reg    <= {~key[31], key[30:0]};
        end
        if (cmd.lvl_init)
        begin
            lvl_reg <= IW'(top_reg - LW'(1));
            cur_reg <= NIL;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                pred_reg[i] <= NIL;
                succ_reg[i] <= head_reg[i];
            end
        end
        if (cmd.rd_key)
        begin
            nx_reg   <= nx_sel;
            nkey_reg <= key_mem[nx_sel[NW-1:0]];
        end
        if (cmd.advance)
            cur_reg <= nx_reg;
        if (!cmd.advance && (cmd.lvl_down || (stat.lvl_zero && !stat.more
            && !cmd.rd_ptr && !cmd.rd_key && !cmd.decide && !cmd.ins_step
            && !cmd.del_step && !cmd.top_step && !cmd.load && !cmd.lvl_init)))
        begin
            pred_reg[lvl_reg] <= cur_reg;
            succ_reg[lvl_reg] <= nx_reg;
            cand_reg          <= nx_reg;
            if (cmd.lvl_down)
                lvl_reg <= lvl_reg - IW'(1);
        end
        // link reads run one level ahead of the update steps
        if (cmd.decide)
        begin
            step_reg    <= '0;
            nn_reg      <= free_top;
            nlv_reg     <= lv_draw;
            del_brk_reg <= 1'b0;
            lvl_reg     <= IW'(1);
            cur_reg     <= cand_reg;
            for (int i = 0; i < MAX_LEVELS; i++)
                if (LW'(i) >= top_reg)
                begin
                    pred_reg[i] <= NIL;
                    succ_reg[i] <= head_reg[i];
                end
        end
        if (cmd.ins_step || cmd.del_step)
        begin
            step_reg <= step_reg + LW'(1);
            lvl_reg  <= IW'(step_reg + LW'(2));
            if (cmd.del_step && succ_reg[sidx] != cand_reg)
                del_brk_reg <= 1'b1;
        end
    end

endmodule

// ===== rtl/skip_list_sorted_set.sv =====
// skip_list_sorted_set: sorted set of signed 32-bit keys held as a skip list
//
// input channel in_valid/in_ready carries func and key; output channel
// out_valid/out_ready carries found and full_res, one result per item.
// func 0 inserts, 1 deletes, 2 (and 3) searches.
// one item is in flight at a time: the block takes an item only while idle.
// after the item is taken the block sets up the top level, then for each
// visited node reads the link memory, reads the key memory and compares;
// it then decides, links the new node one level per step on insert, or
// unlinks one level per step on delete and then lowers the top level.
// the next item is taken only after the result has been delivered.
// reset empties the set: head links null, top level one, every node free.
// no clearing pass is needed, the free stack marks its lowest written entry.
// when the receiver stalls the result holds on the outputs and no new
// item is taken until it is delivered.
module skip_list_sorted_set
    import sls_pkg::*;
#(
    parameter int MAX_LEVELS = 5,
    parameter int POOL_NODES = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [31:0] key,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic               full_res
);

    cmd_t  cmd;
    stat_t stat;

    sls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    sls_dp #(
        .MAX_LEVELS (MAX_LEVELS),
        .POOL_NODES (POOL_NODES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .func     (func),
        .key      (key),
        .cmd      (cmd),
        .stat     (stat),
        .found    (found),
        .full_res (full_res)
    );

    // no input taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // full only flagged on a miss
    a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && full_res))
        else $error("full and found together");

    // result holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(full_res))
        else $error("result changed under stall");

endmodule

// ===== tb/skip_list_sorted_set_tb.sv =====
`timescale 1ns / 1ps

module skip_list_sorted_set_tb
    import sls_pkg::*;
();

    localparam int LEVELS = 5;
    localparam int POOL = 256;
    localparam int NIL = POOL;
    localparam int HEAD = POOL + 1;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 2000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         func;
    logic signed [31:0] key;
    logic               out_valid;
    logic               out_ready;
    logic               found;
    logic               full_res;

    skip_list_sorted_set uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .key(key), .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .full_res(full_res)
    );

    // predictor state: skip list mirror
    logic [31:0] m_keys [POOL];
    int          m_links [POOL][LEVELS];
    int          m_head [LEVELS];
    int          m_top;
    int          m_free [POOL];
    int          m_free_cnt;
    logic [15:0] m_lfsr;

    typedef struct packed {
        logic found;
        logic full;
    } verdict_t;

    verdict_t expected_q [$];
    logic signed [31:0] used_keys [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  mismatches;
    int  results_seen;
    int  items_sent;
    longint cycles;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int next_of(int n, int lvl);
        if (n == HEAD)
            return m_head[lvl];
        return m_links[n][lvl];
    endfunction

    function automatic void set_next(int n, int lvl, int v);
        if (n == HEAD)
            m_head[lvl] = v;
        else
            m_links[n][lvl] = v;
    endfunction

    function automatic void set_reset();
        for (int i = 0; i < LEVELS; i++)
            m_head[i] = NIL;
        for (int i = 0; i < POOL; i++)
            m_free[i] = i;
        m_free_cnt = POOL;
        m_top = 1;
        m_lfsr = LFSR_SEED;
    endfunction

    // apply one operation to the mirror and return the expected verdict
    function automatic verdict_t set_apply(logic [1:0] op, logic [31:0] k_in);
        logic [31:0] k;
        int pred [LEVELS];
        int cur;
        int nx;
        int cand;
        int lv;
        int nn;
        verdict_t v;
        k = k_in ^ 32'h8000_0000;
        cur = HEAD;
        v = '0;
        for (int i = 0; i < LEVELS; i++)
            pred[i] = HEAD;
        for (int l = m_top - 1; l >= 0; l--)
        begin
            nx = next_of(cur, l);
            while (nx < POOL && m_keys[nx] < k)
            begin
                cur = nx;
                nx = next_of(cur, l);
            end
            pred[l] = cur;
        end
        cand = next_of(cur, 0);
        v.found = (cand < POOL) && (m_keys[cand] == k);
        if (op == FUNC_INSERT && !v.found)
        begin
            if (m_free_cnt == 0)
                v.full = 1'b1;
            else
            begin
                m_lfsr = m_lfsr[0] ? ((m_lfsr >> 1) ^ LFSR_TAPS) : (m_lfsr >> 1);
                if (m_lfsr == 16'd0)
                    m_lfsr = LFSR_SEED;
                lv = (m_lfsr % LEVELS) + 1;
                m_free_cnt--;
                nn = m_free[m_free_cnt];
                if (lv > m_top)
                    m_top = lv;
                m_keys[nn] = k;
                for (int i = 0; i < LEVELS; i++)
                    m_links[nn][i] = NIL;
                for (int i = 0; i < lv; i++)
                begin
                    m_links[nn][i] = next_of(pred[i], i);
                    set_next(pred[i], i, nn);
                end
            end
        end
        else if (op == FUNC_DELETE && v.found)
        begin
            for (int i = 0; i < m_top; i++)
            begin
                if (next_of(pred[i], i) != cand)
                    break;
                set_next(pred[i], i, m_links[cand][i]);
            end
            m_free[m_free_cnt] = cand;
            m_free_cnt++;
            while (m_top > 1 && m_head[m_top - 1] == NIL)
                m_top--;
        end
        return v;
    endfunction

    // send one item, predicting its verdict at acceptance; valid stays up
    // into the next item unless the sender idles
    task automatic send_item(logic [1:0] op, logic signed [31:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        key <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(set_apply(op, k));
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result found=%0b full_res=%0b", found, full_res);
            end
            else
            begin
                exp_v = expected_q.pop_front();
                if (found !== exp_v.found || full_res !== exp_v.full)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: expected found=%0b full_res=%0b, got %0b %0b",
                                 results_seen, exp_v.found, exp_v.full, found, full_res);
                end
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 55 && used_keys.size() != 0)
            return used_keys[$urandom_range(used_keys.size() - 1)];
        if (r < 75)
            return $signed($urandom_range(40)) - 20;
        if (r < 85)
            return r[0] ? 32'sh7fff_ffff : 32'sh8000_0000;
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return FUNC_INSERT;
        if (r < 75)
            return FUNC_DELETE;
        if (r < 97)
            return FUNC_SEARCH;
        return FUNC_UNUSED;
    endfunction

    // extremes, every operation, duplicates, absent deletes, unused code
    task automatic test_directed();
        logic signed [31:0] dk [6];
        dk = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 32'sh5555_aaaa};
        send_item(FUNC_SEARCH, 0);
        send_item(FUNC_DELETE, 5);
        foreach (dk[i])
            send_item(FUNC_INSERT, dk[i]);
        send_item(FUNC_INSERT, 32'sh7fff_ffff);
        send_item(FUNC_SEARCH, 32'sh8000_0000);
        send_item(FUNC_SEARCH, 32'sh2aaa_5555);
        send_item(FUNC_UNUSED, -1);
        send_item(FUNC_DELETE, 32'sh8000_0000);
        send_item(FUNC_DELETE, 32'sh8000_0000);
        send_item(FUNC_DELETE, 32'sh7fff_ffff);
        send_item(FUNC_SEARCH, 32'sh7fff_ffff);
        send_item(FUNC_DELETE, 0);
        send_item(FUNC_DELETE, -1);
        send_item(FUNC_DELETE, 1);
        send_item(FUNC_DELETE, 32'sh5555_aaaa);
        send_item(FUNC_SEARCH, 1);
        drain();
    endtask

    // fill the pool, hit the full case, then empty it again
    task automatic test_pool_full();
        for (int i = 0; i < POOL + 3; i++)
            send_item(FUNC_INSERT, 1000 + i * 7);
        send_item(FUNC_INSERT, 1000);
        for (int i = 0; i < POOL; i++)
            send_item(FUNC_DELETE, 1000 + (i * 37 % POOL) * 7);
        drain();
    endtask

    // random traffic under one idling profile
    task automatic test_random(int n, int idle_pct, int stall_pct);
        logic signed [31:0] k;
        logic [1:0] op;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            k = pick_key();
            op = pick_op();
            if (op == FUNC_INSERT && used_keys.size() < 64)
                used_keys.push_back(k);
            send_item(op, k);
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_SEARCH;
        key = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        cycles = 0;
        set_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(130, 0, 0);
        test_random(130, 58, 0);
        test_random(130, 0, 58);
        test_random(123, 9, 9);
        test_pool_full();

        $display("covered %0d items and %0d results: inserts, deletes, searches,",
                 items_sent, results_seen);
        $display("duplicates, absent keys, a full pool and four idling profiles");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sls_pkg.sv
rtl/sls_ctrl.sv
rtl/sls_dp.sv
rtl/skip_list_sorted_set.sv
tb/skip_list_sorted_set_tb.sv
